>>> src/rsda_pkg.sv
// Shared types and constants for the row-store dot product / AXPY block.
// No dependencies; used by the front end, queue, back end and top level.
`timescale 1ns / 1ps
`default_nettype none

package rsda_pkg;

    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_ADD   = 2'd1,
        OP_DOT   = 2'd2
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        ok;
        logic [15:0] value;
        logic [15:0] scale;
        logic        last;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_UPD,
        ST_EMIT
    } back_state_t;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam int ROW_W   = 12;
    localparam int COL_W   = 7;
    localparam int ELEM_W  = 16;
    localparam int ACC_W   = 48;
    localparam int SUM_W   = 32;
    localparam int FRAC_W  = 12;
    localparam int S_TDATA_W = 56;

endpackage

`default_nettype wire

>>> src/rsda_front.sv
// Front end: decodes an input beat into a queue entry and its matrix index.
// Depends on rsda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsda_front #(
    parameter int ROWS = 4096,
    parameter int DIM  = 128,
    parameter int AW   = 19
) (
    input  wire logic [1:0]                   cmd,
    input  wire logic [rsda_pkg::ROW_W-1:0]   row,
    input  wire logic [rsda_pkg::COL_W-1:0]   col,
    input  wire logic [rsda_pkg::ELEM_W-1:0]  value,
    input  wire logic [rsda_pkg::ELEM_W-1:0]  scale,
    input  wire logic                         last,
    output rsda_pkg::item_t                   item,
    output logic [AW-1:0]                     idx,
    output logic                              keep
);

    logic        addr_ok;
    logic [31:0] idx_full;

    assign addr_ok  = (32'(row) < 32'(ROWS)) && (32'(col) < 32'(DIM));
    assign idx_full = 32'(row) * 32'(DIM) + 32'(col);
    assign idx      = idx_full[AW-1:0];

    always_comb begin
        item.op    = rsda_pkg::OP_DOT;
        item.ok    = addr_ok;
        item.value = value;
        item.scale = scale;
        item.last  = last;
        keep       = 1'b0;
        case (cmd)
            rsda_pkg::OP_STORE: begin
                item.op = rsda_pkg::OP_STORE;
                keep    = addr_ok;
            end
            rsda_pkg::OP_ADD: begin
                item.op = rsda_pkg::OP_ADD;
                keep    = addr_ok;
            end
            rsda_pkg::OP_DOT: begin
                item.op = rsda_pkg::OP_DOT;
                keep    = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/rsda_fifo.sv
// Short queue between front and back ends.
// Depends on rsda_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none

module rsda_fifo #(
    parameter int W = 56
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              valid,
    output logic [W-1:0]      pop_data
);

    logic [W-1:0]              entry_reg [rsda_pkg::QDEPTH];
    logic [rsda_pkg::QAW:0]    wptr_reg, wptr_next;
    logic [rsda_pkg::QAW:0]    rptr_reg, rptr_next;

    assign full  = (wptr_reg[rsda_pkg::QAW] != rptr_reg[rsda_pkg::QAW]) &&
                   (wptr_reg[rsda_pkg::QAW-1:0] == rptr_reg[rsda_pkg::QAW-1:0]);
    assign valid = (wptr_reg != rptr_reg);
    assign pop_data = entry_reg[rptr_reg[rsda_pkg::QAW-1:0]];

    assign wptr_next = wptr_reg + (rsda_pkg::QAW+1)'(push && !full);
    assign rptr_next = rptr_reg + (rsda_pkg::QAW+1)'(pop && valid);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wptr_reg[rsda_pkg::QAW-1:0]] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> src/rsda_back.sv
// Back end: matrix memory, shared multiplier, accumulator and result register.
// Depends on rsda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsda_back #(
    parameter int DEPTH = 524288,
    parameter int AW    = 19
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    input  wire rsda_pkg::item_t             q_item,
    input  wire logic [AW-1:0]               q_idx,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [rsda_pkg::SUM_W-1:0]       m_tdata,
    output logic [0:0]                       m_tuser
);

    logic [rsda_pkg::ELEM_W-1:0] mem [DEPTH];

    rsda_pkg::back_state_t state_reg, state_next;

    rsda_pkg::item_t                    item_reg;
    logic [AW-1:0]                      idx_reg;
    logic signed [rsda_pkg::ELEM_W-1:0] rd_data_reg;
    logic signed [31:0]                 prod_reg, prod_next;
    logic signed [rsda_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic                               ovf_reg, ovf_next;
    logic                               out_valid_reg;
    logic [rsda_pkg::SUM_W-1:0]         out_data_reg, out_data_next;
    logic                               out_ovf_reg, out_ovf_next;

    logic                               mem_we;
    logic [AW-1:0]                      mem_waddr;
    logic [rsda_pkg::ELEM_W-1:0]        mem_wdata;
    logic                               acc_upd;
    logic                               out_load;
    logic                               out_free;

    logic signed [rsda_pkg::ELEM_W-1:0] mul_a;
    logic signed [19:0]                 step;
    logic signed [20:0]                 upd_sum;
    logic [rsda_pkg::ELEM_W-1:0]        upd_sat;
    logic signed [rsda_pkg::ACC_W:0]    acc_sum;
    logic signed [31:0]                 addend;
    logic signed [35:0]                 acc_shift;
    logic                               out_sat;

    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rsda_pkg::ST_IDLE: begin
                if (q_valid && q_item.op != rsda_pkg::OP_STORE) begin
                    state_next = rsda_pkg::ST_CALC;
                end
            end
            rsda_pkg::ST_CALC: begin
                state_next = rsda_pkg::ST_UPD;
            end
            rsda_pkg::ST_UPD: begin
                if (item_reg.op == rsda_pkg::OP_DOT && item_reg.last) begin
                    state_next = rsda_pkg::ST_EMIT;
                end else begin
                    state_next = rsda_pkg::ST_IDLE;
                end
            end
            rsda_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = rsda_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rsda_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = q_idx;
        mem_wdata = q_item.value;
        acc_upd   = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            rsda_pkg::ST_IDLE: begin
                q_pop  = q_valid;
                mem_we = q_valid && q_item.op == rsda_pkg::OP_STORE && q_item.ok;
            end
            rsda_pkg::ST_UPD: begin
                mem_waddr = idx_reg;
                mem_wdata = upd_sat;
                mem_we    = item_reg.op == rsda_pkg::OP_ADD && item_reg.ok;
                acc_upd   = item_reg.op == rsda_pkg::OP_DOT;
            end
            rsda_pkg::ST_EMIT: begin
                out_load = out_free;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    // datapath
    assign mul_a     = (item_reg.op == rsda_pkg::OP_ADD) ? $signed(item_reg.scale) : rd_data_reg;
    assign prod_next = mul_a * $signed(item_reg.value);

    assign step    = prod_reg[31:rsda_pkg::FRAC_W];
    assign upd_sum = 21'(rd_data_reg) + 21'(step);
    always_comb begin
        if (upd_sum[20:15] == 6'b000000 || upd_sum[20:15] == 6'b111111) begin
            upd_sat = upd_sum[15:0];
        end else if (upd_sum[20]) begin
            upd_sat = 16'h8000;
        end else begin
            upd_sat = 16'h7FFF;
        end
    end

    assign addend  = item_reg.ok ? prod_reg : 32'sd0;
    assign acc_sum = (rsda_pkg::ACC_W+1)'(acc_reg) + (rsda_pkg::ACC_W+1)'(addend);
    always_comb begin
        acc_next = acc_reg;
        ovf_next = ovf_reg;
        if (acc_upd) begin
            if (acc_sum[rsda_pkg::ACC_W] == acc_sum[rsda_pkg::ACC_W-1]) begin
                acc_next = acc_sum[rsda_pkg::ACC_W-1:0];
            end else begin
                ovf_next = 1'b1;
                acc_next = acc_sum[rsda_pkg::ACC_W] ? {1'b1, {(rsda_pkg::ACC_W-1){1'b0}}}
                                                    : {1'b0, {(rsda_pkg::ACC_W-1){1'b1}}};
            end
        end else if (out_load) begin
            acc_next = '0;
            ovf_next = 1'b0;
        end
    end

    assign acc_shift = acc_reg[rsda_pkg::ACC_W-1:rsda_pkg::FRAC_W];
    assign out_sat   = !(acc_shift[35:31] == 5'b00000 || acc_shift[35:31] == 5'b11111);
    always_comb begin
        if (!out_sat) begin
            out_data_next = acc_shift[31:0];
        end else if (acc_shift[35]) begin
            out_data_next = 32'h8000_0000;
        end else begin
            out_data_next = 32'h7FFF_FFFF;
        end
        out_ovf_next = ovf_reg || out_sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rsda_pkg::ST_IDLE;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
            idx_reg  <= q_idx;
        end
        if (state_reg == rsda_pkg::ST_CALC) begin
            prod_reg <= prod_next;
        end
        if (out_load) begin
            out_data_reg <= out_data_next;
            out_ovf_reg  <= out_ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop) begin
            rd_data_reg <= mem[q_idx];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

`default_nettype wire

>>> src/row_store_dot_and_axpy_top.sv
// Top level of the row-store dot product / AXPY block.
// Depends on rsda_pkg, rsda_front, rsda_fifo and rsda_back.
//
// channel | dir | tdata (low bit up)                      | tuser         | tlast
// s_      | in  | row[11:0] col[18:12] value[34:19]       | cmd[1:0]      | last
//         |     | scale[50:35], zero[55:51]               |               |
// m_      | out | dot_sum[31:0]                           | overflow[0]   | -
//
// Store: written to memory as the beat is popped. Add-scaled and dot: memory read
// register, multiplier register, then accumulate/write. A dot beat with last also
// loads the result register. A 4-entry queue decouples input from back end.
// Reset clears the accumulator, flags and queue; the matrix memory is not
// cleared. Stalls on m_ hold the back end only once the result register is full.
`timescale 1ns / 1ps
`default_nettype none

module row_store_dot_and_axpy_top #(
    parameter int ROWS = 4096,
    parameter int DIM  = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [rsda_pkg::S_TDATA_W-1:0] s_tdata,   // row, col, value, scale, pad
    input  wire logic [1:0]  s_tuser,   // cmd
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // dot_sum
    output logic [0:0]       m_tuser    // overflow
);

    localparam int DEPTH = ROWS * DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = $bits(rsda_pkg::item_t);
    localparam int QW    = AW + IW;

    rsda_pkg::item_t f_item;
    logic [AW-1:0]   f_idx;
    logic            f_keep;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic [QW-1:0]   q_out;
    rsda_pkg::item_t q_item;
    logic [AW-1:0]   q_idx;

    rsda_front #(
        .ROWS (ROWS),
        .DIM  (DIM),
        .AW   (AW)
    ) u_front (
        .cmd   (s_tuser),
        .row   (s_tdata[11:0]),
        .col   (s_tdata[18:12]),
        .value (s_tdata[34:19]),
        .scale (s_tdata[50:35]),
        .last  (s_tlast),
        .item  (f_item),
        .idx   (f_idx),
        .keep  (f_keep)
    );

    assign s_tready = !q_full;

    rsda_fifo #(
        .W (QW)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid && f_keep),
        .push_data ({f_idx, f_item}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    assign q_item = q_out[IW-1:0];
    assign q_idx  = q_out[QW-1:IW];

    rsda_back #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_idx    (q_idx),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

>>> src/rsda_checker.sv
// Port-level checks for row_store_dot_and_axpy_top, bound to the top level.
// Depends on row_store_dot_and_axpy_top.
`timescale 1ns / 1ps
`default_nettype none

module rsda_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    a_ready_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> s_tready)
        else $error("queue not empty after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

endmodule

bind row_store_dot_and_axpy_top rsda_checker u_rsda_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> verif/row_store_dot_and_axpy_top_tb.sv
// Testbench for row_store_dot_and_axpy_top: directed, saturation and random
// store/add-scaled/dot streams checked against an in-bench scoreboard.
// Depends on rsda_pkg and the RTL of the block.
`timescale 1ns / 1ps

module row_store_dot_and_axpy_top_tb;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         ITEMS_PER_PHASE = 100;
    localparam int         LONG_VEC_LEN   = 48;

    class dot_axpy_scoreboard;
        typedef struct packed {
            logic [31:0] sum;
            logic        ov;
        } dot_result_t;

        logic signed [15:0] elem [int];
        int                 filled[$];
        longint             acc;
        bit                 acc_ov;
        dot_result_t        expected_dots[$];
        int                 mismatches;

        function new();
            acc = 0;
            acc_ov = 0;
            mismatches = 0;
        endfunction

        function void note_beat(logic [1:0] cmd, logic [11:0] row, logic [6:0] col,
                                logic [15:0] value, logic [15:0] scale, logic last);
            int          key;
            longint      stored;
            longint      v;
            longint      s;
            longint      t;
            longint      r;
            bit          ov;
            dot_result_t res;
            key = int'({row, col});
            v = longint'($signed(value));
            s = longint'($signed(scale));
            stored = elem.exists(key) ? longint'(elem[key]) : 0;
            case (cmd)
                rsda_pkg::OP_STORE: begin
                    if (!elem.exists(key))
                        filled.push_back(key);
                    elem[key] = value;
                end
                rsda_pkg::OP_ADD: begin
                    t = stored + ((s * v) >>> rsda_pkg::FRAC_W);
                    if (t > 32767) t = 32767;
                    if (t < -32768) t = -32768;
                    elem[key] = t[15:0];
                end
                rsda_pkg::OP_DOT: begin
                    t = acc + stored * v;
                    if (t > (64'sd1 <<< 47) - 1) begin
                        t = (64'sd1 <<< 47) - 1;
                        acc_ov = 1;
                    end
                    if (t < -(64'sd1 <<< 47)) begin
                        t = -(64'sd1 <<< 47);
                        acc_ov = 1;
                    end
                    acc = t;
                    if (last) begin
                        r = acc >>> rsda_pkg::FRAC_W;
                        ov = acc_ov;
                        if (r > 64'sd2147483647) begin
                            r = 64'sd2147483647;
                            ov = 1;
                        end
                        if (r < -64'sd2147483648) begin
                            r = -64'sd2147483648;
                            ov = 1;
                        end
                        res.sum = r[31:0];
                        res.ov = ov;
                        expected_dots.push_back(res);
                        acc = 0;
                        acc_ov = 0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_dot(logic [31:0] sum, logic ov);
            dot_result_t exp_res;
            if (expected_dots.size() == 0) begin
                $display("%0t: unexpected dot beat: expected none, got sum %0d ov %0b",
                         $time, $signed(sum), ov);
                mismatches++;
                return;
            end
            exp_res = expected_dots.pop_front();
            if (exp_res.sum !== sum || exp_res.ov !== ov) begin
                $display("%0t: dot mismatch: expected sum %0d ov %0b, got sum %0d ov %0b",
                         $time, $signed(exp_res.sum), exp_res.ov, $signed(sum), ov);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int idle_cycles = 0;

    dot_axpy_scoreboard sb = new();

    row_store_dot_and_axpy_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // row[11:0] col[18:12] value[34:19] scale[50:35] zero[55:51]
        .s_tuser  (s_tuser),   // cmd[1:0]
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // dot_sum[31:0]
        .m_tuser  (m_tuser)    // overflow[0]
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_dot(m_tdata, m_tuser[0]);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no beat moved for %0d cycles", $time, idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [15:0] pick_q312();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h1000;
            3: return $urandom_range(1) ? 16'hffff : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // half the time one of the four latest entries (if more than four), to stress back-to-back hazards on one address
    function automatic int pick_stored_addr();
        int n;
        n = sb.filled.size();
        if ($urandom_range(1) && n > 4)
            return sb.filled[n - 1 - $urandom_range(3)];
        return sb.filled[$urandom_range(n - 1)];
    endfunction

    task automatic send_beat(logic [1:0] cmd, logic [11:0] row, logic [6:0] col,
                             logic [15:0] value, logic [15:0] scale, logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tlast  <= last;
        s_tdata  <= {5'b0, scale, value, col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_beat(cmd, row, col, value, scale, last);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_dots.size() != 0) @(posedge aclk);
    endtask

    task automatic run_random(int n);
        int sent;
        int kind;
        int len;
        int key;
        int i;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(99);
            if (kind < 25 || sb.filled.size() == 0) begin
                len = $urandom_range(1, 6);
                for (i = 0; i < len; i++) begin
                    send_beat(rsda_pkg::OP_STORE,
                              12'(($urandom_range(9) < 7) ? $urandom_range(7)
                                                          : $urandom_range(4095)),
                              7'(($urandom_range(9) < 7) ? $urandom_range(3)
                                                         : $urandom_range(127)),
                              pick_q312(), 16'($urandom), 1'($urandom_range(1)));
                    sent++;
                end
            end else if (kind < 45) begin
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++) begin
                    key = pick_stored_addr();
                    send_beat(rsda_pkg::OP_ADD, 12'(key >> 7), key[6:0], pick_q312(),
                              pick_q312(), 1'($urandom_range(1)));
                    sent++;
                end
            end else if (kind < 92) begin
                len = $urandom_range(1, 8);
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(9) == 0) begin
                        send_beat($urandom_range(1) ? CMD_UNUSED : rsda_pkg::OP_STORE,
                                  12'($urandom), 7'($urandom), pick_q312(),
                                  16'($urandom), 1'b1);
                    end
                    key = pick_stored_addr();
                    send_beat(rsda_pkg::OP_DOT, 12'(key >> 7), key[6:0], pick_q312(),
                              16'($urandom), i == len - 1);
                    sent++;
                end
            end else begin
                send_beat(CMD_UNUSED, 12'($urandom), 7'($urandom), 16'($urandom),
                          16'($urandom), 1'($urandom_range(1)));
            end
        end
    endtask

    int tx_pct[4] = '{0, 82, 0, 25};
    int rx_pct[4] = '{0, 0, 82, 25};

    initial begin
        int ph;
        int i;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, saturation of add, ignored last, unused cmd
        send_beat(rsda_pkg::OP_STORE, 12'd0, 7'd0, 16'h7fff, 16'h0000, 1'b0);
        send_beat(rsda_pkg::OP_STORE, 12'd4095, 7'd127, 16'h8000, 16'hffff, 1'b0);
        send_beat(rsda_pkg::OP_STORE, 12'd1, 7'd1, 16'h1000, 16'h0000, 1'b0);
        send_beat(rsda_pkg::OP_STORE, 12'd2, 7'd2, 16'hffff, 16'h0000, 1'b1);
        send_beat(rsda_pkg::OP_ADD, 12'd1, 7'd1, 16'h7fff, 16'h7fff, 1'b0);
        send_beat(rsda_pkg::OP_ADD, 12'd4095, 7'd127, 16'h7fff, 16'h8000, 1'b0);
        send_beat(rsda_pkg::OP_ADD, 12'd2, 7'd2, 16'h0001, 16'hffff, 1'b1);
        send_beat(CMD_UNUSED, 12'd4095, 7'd127, 16'hffff, 16'hffff, 1'b1);
        send_beat(rsda_pkg::OP_DOT, 12'd0, 7'd0, 16'h7fff, 16'hffff, 1'b0);
        send_beat(rsda_pkg::OP_DOT, 12'd4095, 7'd127, 16'h8000, 16'h0000, 1'b0);
        send_beat(rsda_pkg::OP_DOT, 12'd1, 7'd1, 16'h8000, 16'h0000, 1'b1);
        send_beat(rsda_pkg::OP_DOT, 12'd2, 7'd2, 16'h7fff, 16'h0000, 1'b1);
        send_beat(rsda_pkg::OP_STORE, 12'd5, 7'd5, 16'h8000, 16'h0000, 1'b0);
        send_beat(rsda_pkg::OP_ADD, 12'd5, 7'd5, 16'h8000, 16'h1000, 1'b0);
        send_beat(rsda_pkg::OP_DOT, 12'd5, 7'd5, 16'h8000, 16'h0000, 1'b1);
        send_beat(rsda_pkg::OP_STORE, 12'd3, 7'd3, 16'h8000, 16'h0000, 1'b0);

        // long vectors of extreme products, positive and negative sums
        for (i = 0; i < LONG_VEC_LEN; i++)
            send_beat(rsda_pkg::OP_DOT, 12'd3, 7'd3, 16'h8000, 16'h0000,
                      i == LONG_VEC_LEN - 1);
        for (i = 0; i < LONG_VEC_LEN; i++)
            send_beat(rsda_pkg::OP_DOT, 12'd3, 7'd3, 16'h7fff, 16'h0000,
                      i == LONG_VEC_LEN - 1);

        for (ph = 0; ph < 4; ph++) begin
            tx_idle_pct = tx_pct[ph];
            rx_stall_pct = rx_pct[ph];
            run_random(ITEMS_PER_PHASE);
            drain();
        end

        repeat (16) @(posedge aclk);
        while (sb.expected_dots.size() != 0) begin
            $display("%0t: missing dot beat: expected sum %0d ov %0b, got none",
                     $time, $signed(sb.expected_dots[0].sum), sb.expected_dots[0].ov);
            void'(sb.expected_dots.pop_front());
            sb.mismatches++;
        end
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> sim.f
src/rsda_pkg.sv
src/rsda_front.sv
src/rsda_fifo.sv
src/rsda_back.sv
src/row_store_dot_and_axpy_top.sv
src/rsda_checker.sv
verif/row_store_dot_and_axpy_top_tb.sv
